// ----- rtl/core/multiplicative_hash_key_value_store_defines.svh -----
// Assertion macros for the key-value store.
`ifndef MULTIPLICATIVE_HASH_KEY_VALUE_STORE_DEFINES_SVH
`define MULTIPLICATIVE_HASH_KEY_VALUE_STORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define MHKV_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MHKV_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MHKV_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define MHKV_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ----- rtl/core/mhkv_pkg.sv -----
package mhkv_pkg;
    localparam int Buckets   = 64;
    localparam int Ways      = 4;
    localparam int Slots     = Buckets * Ways;
    localparam int SlotW     = $clog2(Slots);
    localparam int WayW      = (Ways > 1) ? $clog2(Ways) : 1;
    localparam int WayCntW   = $clog2(Ways + 1);
    localparam logic [6:0]  SizeReset = 7'd7;
    localparam logic [31:0] GoldenQ32 = 32'h9E3779B9;

    typedef enum logic [1:0] {
        FUNC_INSERT   = 2'd0,
        FUNC_REMOVE   = 2'd1,
        FUNC_CONTAINS = 2'd2,
        FUNC_LOOKUP   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]  func;
        logic signed [31:0] key_in;
        logic signed [31:0] value_in;
    } t_req;

    typedef struct packed {
        logic        found;
        logic signed [31:0] value_out;
        logic [1:0]  status;
        logic [6:0]  bucket_index;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE, S_MOD1, S_H0, S_MULA, S_MULB, S_MOD2, S_SCAN, S_WAIT, S_SCANCHK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       start;
        logic [63:0] dividend;
        logic [6:0] divisor;
    } t_mod_req;

    typedef struct packed {
        logic       done;
        logic [6:0] rem;
    } t_mod_rsp;
endpackage

// ----- rtl/core/mhkv_mod.sv -----
module mhkv_mod (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mhkv_pkg::t_mod_req i_req,
    output mhkv_pkg::t_mod_rsp o_rsp
);
    import mhkv_pkg::*;
    // restoring remainder, one dividend bit per cycle
    logic [63:0] r_dvd, n_dvd;
    logic [7:0]  r_rem, n_rem;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_done, n_done;
    logic [7:0]  shifted;

    always_comb begin
        shifted = {r_rem[6:0], r_dvd[63]};
        n_dvd = r_dvd; n_rem = r_rem; n_cnt = r_cnt;
        n_busy = r_busy; n_done = 1'b0;
        if (i_req.start) begin
            n_dvd = i_req.dividend; n_rem = '0; n_cnt = 7'd64; n_busy = 1'b1;
        end else if (r_busy) begin
            n_dvd = {r_dvd[62:0], 1'b0};
            n_rem = (shifted >= {1'b0, i_req.divisor}) ?
                    shifted - {1'b0, i_req.divisor} : shifted;
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd; r_rem <= n_rem; r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_busy <= n_busy; r_done <= n_done;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem[6:0];
endmodule

// ----- rtl/core/multiplicative_hash_key_value_store.sv -----
// Hash key-value store, one operation per transaction. Pulse start while
// busy is low; busy rises at once, and the result appears on o_rsp with
// o_done high for exactly one cycle. The work runs through two 64-step
// serial remainder passes in one shared bit-serial unit, with the hash
// arithmetic (S_H0, S_MULA, S_MULB) between them, then the bucket scan,
// the way evaluation and the response. The four ways of the bucket are
// read from the key and value memories, one per cycle. busy falls in the
// same cycle that o_done is high, so the next transaction can be taken on
// the edge that takes the result; a new transaction is taken only while
// busy is low. The receiver cannot stall; take the result when o_done is
// high. Write i_cfg_wr/i_cfg_data only while busy is low.
`include "multiplicative_hash_key_value_store_defines.svh"
module multiplicative_hash_key_value_store (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  mhkv_pkg::t_req    i_req,
    output logic              o_done,
    output mhkv_pkg::t_rsp    o_rsp,
    input  logic              i_cfg_wr,
    input  logic [6:0]        i_cfg_data
);
    import mhkv_pkg::*;

    t_state r_state, n_state;
    t_req   r_req;
    logic [6:0]  r_size, r_s;
    logic        r_neg;
    logic [31:0] r_mag;
    logic [6:0]  r_h0;
    logic [13:0] r_p;
    logic [45:0] r_prod;
    logic [6:0]  r_bucket;
    logic [WayCntW-1:0] r_way;
    logic        r_hit_v, r_both_v, r_free_v;
    logic [WayW-1:0] r_hit, r_both, r_free;
    logic [Slots-1:0] r_valid;
    logic [31:0] mem_key [Slots];
    logic [31:0] mem_val [Slots];
    logic [31:0] r_rd_key, r_rd_val, r_hit_val;
    logic [WayW-1:0] r_rd_way;
    logic        r_rd_ok;
    t_mod_req mreq;
    t_mod_rsp mrsp;
    t_rsp     r_rsp;
    logic     r_done;
    logic [SlotW-1:0] base_slot, rd_slot, wr_slot;
    logic     do_write;
    logic [WayW-1:0] wr_way;

    mhkv_mod u_mod (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(mreq), .o_rsp(mrsp));

    assign busy = (r_state != S_IDLE);
    // slot address of the bucket base; an out-of-range bucket is impossible
    assign base_slot = SlotW'(r_bucket) * SlotW'(Ways);
    assign rd_slot   = base_slot + SlotW'(r_way);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (start) n_state = S_MOD1;
            S_MOD1:    if (mrsp.done) n_state = S_H0;
            S_H0:      n_state = S_MULA;
            S_MULA:    n_state = S_MULB;
            S_MULB:    n_state = S_MOD2;
            S_MOD2:    if (mrsp.done) n_state = S_SCAN;
            S_SCAN:    n_state = (r_way == WayCntW'(Ways)) ? S_WAIT : S_SCAN;
            S_WAIT:    n_state = S_SCANCHK;
            S_SCANCHK: n_state = S_DONE;
            S_DONE:    n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // outputs to the shared remainder unit
    always_comb begin
        mreq.start    = 1'b0;
        mreq.dividend = {32'd0, r_mag};
        mreq.divisor  = r_s;
        unique case (r_state)
            S_IDLE:  begin
                // feed the key magnitude straight from the port on the accepting edge
                mreq.start    = start;
                mreq.dividend = {32'd0, i_req.key_in[31] ? (32'd0 - i_req.key_in)
                                                         : i_req.key_in};
            end
            S_MULB:  begin
                // floor of the Q14.32 product: drop the 32 fraction bits
                mreq.start    = 1'b1;
                mreq.dividend = {50'd0, r_prod[45:32]};
            end
            default: mreq.start = 1'b0;
        endcase
    end

    // write decision at the end of the scan
    always_comb begin
        do_write = 1'b0; wr_way = r_free;
        if (r_state == S_DONE && t_func'(r_req.func) == FUNC_INSERT) begin
            if (r_hit_v) begin
                do_write = 1'b1; wr_way = r_hit;
            end else if (r_free_v) begin
                do_write = 1'b1;
            end
        end
    end
    assign wr_slot = base_slot + SlotW'(wr_way);

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            mem_key[wr_slot] <= r_req.key_in;
            mem_val[wr_slot] <= r_req.value_in;
        end
        r_rd_key <= mem_key[rd_slot];
        r_rd_val <= mem_val[rd_slot];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_req <= i_req;
            r_s   <= (r_size == 7'd0) ? 7'd1 :
                     (r_size > 7'(Buckets)) ? 7'(Buckets) : r_size;
            r_neg <= i_req.key_in[31];
            r_mag <= i_req.key_in[31] ? (32'd0 - i_req.key_in) : i_req.key_in;
        end
        if (r_state == S_MOD1 && mrsp.done)
            r_h0 <= r_neg ? (r_s - mrsp.rem) : mrsp.rem;
        if (r_state == S_H0) r_p <= 14'(r_h0) * 14'(r_s);
        if (r_state == S_MULA) r_prod <= 46'(r_p) * 46'(GoldenQ32);
        if (r_state == S_MOD2 && mrsp.done) begin
            r_bucket <= mrsp.rem;
            r_way <= '0; r_hit_v <= 1'b0; r_both_v <= 1'b0; r_free_v <= 1'b0;
            r_rd_ok <= 1'b0;
        end
        if (r_state == S_SCAN) begin
            r_way    <= r_way + WayCntW'(1);
            r_rd_way <= WayW'(r_way);
            r_rd_ok  <= (r_way != WayCntW'(Ways));
        end
        // evaluate the way whose memory data arrived this cycle
        if ((r_state == S_SCAN || r_state == S_WAIT) && r_rd_ok) begin
            if (r_valid[base_slot + SlotW'(r_rd_way)]) begin
                if (r_rd_key == r_req.key_in) begin
                    if (!r_hit_v) begin
                        r_hit_v <= 1'b1; r_hit <= r_rd_way; r_hit_val <= r_rd_val;
                    end
                    if (!r_both_v && r_rd_val == r_req.value_in) begin
                        r_both_v <= 1'b1; r_both <= r_rd_way;
                    end
                end
            end else if (!r_free_v) begin
                r_free_v <= 1'b1; r_free <= r_rd_way;
            end
        end
        if (r_state == S_WAIT) r_rd_ok <= 1'b0;
        if (r_state == S_DONE) begin
            r_rsp.bucket_index <= r_bucket;
            r_rsp.found        <= 1'b0;
            r_rsp.value_out    <= '0;
            r_rsp.status       <= ST_NOTFOUND;
            unique case (t_func'(r_req.func))
                FUNC_INSERT: begin
                    r_rsp.found  <= r_hit_v;
                    r_rsp.status <= (r_hit_v || r_free_v) ? ST_DONE : ST_FULL;
                end
                FUNC_REMOVE, FUNC_CONTAINS: if (r_both_v) begin
                    r_rsp.found <= 1'b1; r_rsp.status <= ST_DONE;
                end
                FUNC_LOOKUP: if (r_hit_v) begin
                    r_rsp.found <= 1'b1; r_rsp.status <= ST_DONE;
                    r_rsp.value_out <= r_hit_val;
                end
                default: r_rsp.found <= 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_size  <= SizeReset;
            r_valid <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_DONE);
            if (i_cfg_wr) r_size <= i_cfg_data;
            if (do_write) r_valid[wr_slot] <= 1'b1;
            if (r_state == S_DONE && t_func'(r_req.func) == FUNC_REMOVE && r_both_v)
                r_valid[base_slot + SlotW'(r_both)] <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    `MHKV_ASSERT_IMPL(a_done_pulse, i_clk, i_rst_n, o_done |=> !o_done, "done held")
    `MHKV_ASSERT_IMPL(a_busy_after_start, i_clk, i_rst_n, (start && !busy) |=> busy, "no busy")
    `MHKV_ASSERT_IMPL(a_bucket_range, i_clk, i_rst_n, o_done |-> (o_rsp.bucket_index < 7'(Buckets)), "bucket")
endmodule

// ----- sim/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import mhkv_pkg::*;

    localparam int NumRandom = 1430;
    // Cycle limit for the whole run; allow a wide margin for sender gaps and
    // the settle pauses.
    localparam int CycleLimit = 1_000_000;
    localparam int SettleCycles = 300;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_req i_req;
    logic o_done;
    t_rsp o_rsp;
    logic i_cfg_wr;
    logic [6:0] i_cfg_data;

    multiplicative_hash_key_value_store uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_req(i_req),
        .o_done(o_done),
        .o_rsp(o_rsp),
        .i_cfg_wr(i_cfg_wr),
        .i_cfg_data(i_cfg_data)
    );

    // Shadow copy of the table, kept in step with every accepted transaction.
    logic        shadow_valid [Slots];
    logic [31:0] shadow_key   [Slots];
    logic [31:0] shadow_value [Slots];
    logic [6:0]  shadow_size;

    t_req pending_ops [$];
    t_rsp expected_rsp [$];
    int   error_count;
    int   rsp_count;
    int   full_count;
    int   cycle_count;
    int   gap_left;
    bit   gaps_on;
    bit   hold_send;

    // Key pool kept small so that inserts, hits and full buckets all happen.
    logic [31:0] key_pool [16];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int clamp_size(input logic [6:0] raw);
        if (raw < 7'd1) return 1;
        if (raw > 7'(Buckets)) return Buckets;
        return int'(raw);
    endfunction

    function automatic logic [6:0] golden_bucket(input logic [31:0] key, input int s);
        logic [31:0]  mag;
        logic [31:0]  rem;
        logic [63:0]  h0;
        logic [127:0] prod;
        logic [63:0]  floored;
        mag = key[31] ? (32'd0 - key) : key;
        rem = mag % 32'(s);
        h0 = key[31] ? 64'(32'(s) - rem) : 64'(rem);
        prod = 128'(h0 * 64'(s)) * 128'(GoldenQ32);
        floored = prod[95:32];
        return 7'(floored % 64'(s));
    endfunction

    // Apply one operation to the shadow table and return its expected response.
    function automatic t_rsp apply_op(input t_req op);
        t_rsp r;
        int   s;
        int   b;
        int   hit;
        int   both;
        int   free_slot;
        s = clamp_size(shadow_size);
        b = int'(golden_bucket(op.key_in, s));
        hit = -1;
        both = -1;
        free_slot = -1;
        for (int w = 0; w < Ways; w++) begin
            int i;
            i = b * Ways + w;
            if (shadow_valid[i]) begin
                if (shadow_key[i] == op.key_in) begin
                    if (hit < 0) hit = i;
                    if (both < 0 && shadow_value[i] == op.value_in) both = i;
                end
            end else if (free_slot < 0) begin
                free_slot = i;
            end
        end
        r = '0;
        r.status = ST_NOTFOUND;
        r.bucket_index = 7'(b);
        case (t_func'(op.func))
            FUNC_INSERT: begin
                if (hit >= 0) begin
                    shadow_value[hit] = op.value_in;
                    r.found = 1'b1;
                    r.status = ST_DONE;
                end else if (free_slot >= 0) begin
                    shadow_valid[free_slot] = 1'b1;
                    shadow_key[free_slot] = op.key_in;
                    shadow_value[free_slot] = op.value_in;
                    r.status = ST_DONE;
                end else begin
                    r.status = ST_FULL;
                end
            end
            FUNC_REMOVE: begin
                if (both >= 0) begin
                    shadow_valid[both] = 1'b0;
                    r.found = 1'b1;
                    r.status = ST_DONE;
                end
            end
            FUNC_CONTAINS: begin
                if (both >= 0) begin
                    r.found = 1'b1;
                    r.status = ST_DONE;
                end
            end
            default: begin
                if (hit >= 0) begin
                    r.found = 1'b1;
                    r.value_out = shadow_value[hit];
                    r.status = ST_DONE;
                end
            end
        endcase
        return r;
    endfunction

    function automatic t_req make_op(input t_func f, input logic [31:0] k,
                                     input logic [31:0] v);
        t_req op;
        op.func = f;
        op.key_in = k;
        op.value_in = v;
        return op;
    endfunction

    // Draw a random operation: mostly pool keys and small values, some noise.
    function automatic t_req random_op();
        t_req op;
        op.func = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 9) < 8) begin
            op.key_in = key_pool[$urandom_range(0, 15)];
        end else begin
            op.key_in = $urandom;
        end
        op.value_in = ($urandom_range(0, 3) != 0) ? 32'($urandom_range(0, 3)) : $urandom;
        return op;
    endfunction

    // Driver: present the next queued transaction; idle in random bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_left <= 0;
        end else if (start && !busy) begin
            // Transaction taken this edge; drop start and maybe open a gap.
            start <= 1'b0;
            gap_left <= (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
        end else if (!start) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else if (!hold_send && pending_ops.size() > 0) begin
                i_req <= pending_ops[0];
                expected_rsp.push_back(apply_op(pending_ops.pop_front()));
                start <= 1'b1;
            end
        end
    end

    // Monitor: compare each strobed response with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_rsp.size() == 0) begin
                $display("%0t: unexpected response %h", $time, o_rsp);
                error_count++;
            end else begin
                t_rsp exp_r;
                exp_r = expected_rsp.pop_front();
                rsp_count++;
                if (o_rsp.status == ST_FULL) full_count++;
                if (o_rsp.found !== exp_r.found)
                    $display("%0t: found expected %0b actual %0b", $time,
                             exp_r.found, o_rsp.found);
                if (o_rsp.value_out !== exp_r.value_out)
                    $display("%0t: value_out expected %h actual %h", $time,
                             exp_r.value_out, o_rsp.value_out);
                if (o_rsp.status !== exp_r.status)
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_r.status, o_rsp.status);
                if (o_rsp.bucket_index !== exp_r.bucket_index)
                    $display("%0t: bucket_index expected %0d actual %0d", $time,
                             exp_r.bucket_index, o_rsp.bucket_index);
                if (o_rsp !== exp_r) error_count++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    // Hold until every queued transaction has been answered and the block idles.
    task automatic drain();
        while (pending_ops.size() > 0 || start || expected_rsp.size() > 0)
            @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [6:0] sz);
        i_cfg_data <= sz;
        i_cfg_wr <= 1'b1;
        @(posedge i_clk);
        i_cfg_wr <= 1'b0;
        shadow_size = sz;
        @(posedge i_clk);
    endtask

    task automatic fill_pool();
        for (int i = 0; i < 16; i++) key_pool[i] = $urandom;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'hFFFF_FFFF;
        key_pool[3] = 32'd0;
        key_pool[4] = 32'(-int'(shadow_size));
    endtask

    initial begin
        logic [6:0] sizes [6];
        sizes = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd3, 7'd13};
        for (int i = 0; i < Slots; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_key[i] = '0;
            shadow_value[i] = '0;
        end
        shadow_size = SizeReset;
        error_count = 0;
        rsp_count = 0;
        full_count = 0;
        cycle_count = 0;
        gaps_on = 1'b1;
        hold_send = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req = '0;
        i_cfg_wr = 1'b0;
        i_cfg_data = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extreme keys at the reset size, miss first, then fill a
        // bucket past its ways (keys that are equal mod 7 share a bucket).
        pending_ops.push_back(make_op(FUNC_LOOKUP, 32'd5, 32'd0));
        pending_ops.push_back(make_op(FUNC_INSERT, 32'h8000_0000, 32'h7FFF_FFFF));
        pending_ops.push_back(make_op(FUNC_INSERT, 32'h7FFF_FFFF, 32'h8000_0000));
        pending_ops.push_back(make_op(FUNC_INSERT, 32'hFFFF_FFF9, 32'hFFFF_FFFF));
        pending_ops.push_back(make_op(FUNC_LOOKUP, 32'h8000_0000, 32'd0));
        pending_ops.push_back(make_op(FUNC_CONTAINS, 32'h7FFF_FFFF, 32'h8000_0000));
        pending_ops.push_back(make_op(FUNC_CONTAINS, 32'h7FFF_FFFF, 32'd1));
        for (int i = 0; i < 6; i++)
            pending_ops.push_back(make_op(FUNC_INSERT, 32'(i * 7), 32'(i)));
        pending_ops.push_back(make_op(FUNC_INSERT, 32'd7, 32'd99));
        pending_ops.push_back(make_op(FUNC_LOOKUP, 32'd7, 32'd0));
        pending_ops.push_back(make_op(FUNC_REMOVE, 32'd7, 32'd1));
        pending_ops.push_back(make_op(FUNC_REMOVE, 32'd7, 32'd99));
        pending_ops.push_back(make_op(FUNC_REMOVE, 32'd7, 32'd99));
        pending_ops.push_back(make_op(FUNC_INSERT, 32'd35, 32'd5));
        pending_ops.push_back(make_op(FUNC_LOOKUP, 32'hFFFF_FFF9, 32'd0));
        drain();

        // Random phases, each at its own table size.
        for (int p = 0; p < 6; p++) begin
            write_size(sizes[p]);
            fill_pool();
            if (p == 5) gaps_on = 1'b0;
            for (int n = 0; n < NumRandom / 6; n++) begin
                pending_ops.push_back(random_op());
                // Once per phase, let the queue run dry so the sender waits on the block.
                if (n == 40) begin
                    while (pending_ops.size() > 0 || start) @(posedge i_clk);
                    hold_send = 1'b1;
                    while (expected_rsp.size() > 0) @(posedge i_clk);
                    hold_send = 1'b0;
                end
            end
            drain();
        end

        $display("Checked %0d responses over six table sizes (1 to 64, plus 0 and 127)",
                 rsp_count);
        $display("including %0d full-bucket inserts and extreme signed keys", full_count);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/mhkv_pkg.sv
rtl/core/mhkv_mod.sv
rtl/core/multiplicative_hash_key_value_store.sv
sim/tb_top.sv
